@@ hw/rtl/dwr_pkg.sv @@
// Package for the deque with reverse: request/result beat types,
// request codes, error codes and cell operations. No dependencies.
package dwr_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH_BACK = 2'd0,
        MODE_POP_FRONT = 2'd1,
        MODE_POP_BACK  = 2'd2,
        MODE_REVERSE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LOWER = 2'd1,
        CELL_FROM_UPPER = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               popped_valid;
        err_t               error_code;
        logic [4:0]         entry_count;
    } rsp_t;

endpackage

@@ hw/rtl/dwr_cell.sv @@
// One storage cell of the deque chain: holds a word, or takes it from
// a neighbor or from the push word. Depends on dwr_pkg.
module dwr_cell (
    input  logic                clk,
    input  dwr_pkg::cell_op_t   op,
    input  logic signed [31:0]  lower_data,
    input  logic signed [31:0]  upper_data,
    input  logic signed [31:0]  load_data,
    output logic signed [31:0]  data
);
    import dwr_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        case (op)
            CELL_FROM_LOWER: data_next = lower_data;
            CELL_FROM_UPPER: data_next = upper_data;
            CELL_LOAD:       data_next = load_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/deque_with_reverse_top.sv @@
// Top level of the deque with reverse: a chain of DEPTH cells, count and
// direction control, and a registered result stage. Depends on dwr_pkg, dwr_cell.
//
//  channel | signals                       | beat
//  --------+-------------------------------+--------------------------
//  request | in_valid, in_stall, in_data   | req_t: mode, push_value
//  result  | out_valid, out_stall, out_data| rsp_t: popped word, error, count
//
// One request per cycle while in_stall is low; its result appears in the output
// register on the next cycle. The chain shifts by one cell per request at most.
// rst_n clears count, direction and the output valid; cell words are not reset.
// in_stall is high while a result waits in the output register under out_stall.
module deque_with_reverse_top #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dwr_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output dwr_pkg::rsp_t out_data
);
    import dwr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          out_valid_reg;
    rsp_t          out_data_reg, out_data_next;

    logic signed [31:0] cell_data [DEPTH];
    cell_op_t           cell_op   [DEPTH];

    logic          accept;
    logic          full, empty;
    logic          do_push, do_pop_front, do_pop_back;
    logic          shift_up, shift_down;
    logic          take_tail, take_head;
    logic [IW-1:0] tail_idx;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign tail_idx = IW'(count_reg - CW'(1));

    assign do_push      = accept && (in_data.mode == MODE_PUSH_BACK) && !full;
    assign do_pop_front = accept && (in_data.mode == MODE_POP_FRONT) && !empty;
    assign do_pop_back  = accept && (in_data.mode == MODE_POP_BACK)  && !empty;

    // normal order: cell 0 is front; reversed: cell 0 is back
    assign shift_up   = do_push && rev_reg;
    assign shift_down = (do_pop_front && !rev_reg) || (do_pop_back && rev_reg);
    assign take_head  = shift_down;
    assign take_tail  = (do_pop_front && rev_reg) || (do_pop_back && !rev_reg);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] lower_d, upper_d;

        if (i == 0)
        begin : g_bottom
            assign lower_d = in_data.push_value;
        end
        else
        begin : g_lower
            assign lower_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign upper_d = cell_data[i];
        end
        else
        begin : g_upper
            assign upper_d = cell_data[i+1];
        end

        always_comb
        begin
            if (shift_up)
                cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LOWER;
            else if (shift_down)
                cell_op[i] = (i == DEPTH - 1) ? CELL_HOLD : CELL_FROM_UPPER;
            else if (do_push && (count_reg == CW'(i)))
                cell_op[i] = CELL_LOAD;
            else
                cell_op[i] = CELL_HOLD;
        end

        dwr_cell u_cell (
            .clk        (clk),
            .op         (cell_op[i]),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .load_data  (in_data.push_value),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        rev_next   = rev_reg;
        if (do_push)
            count_next = count_reg + CW'(1);
        else if (do_pop_front || do_pop_back)
            count_next = count_reg - CW'(1);
        if (accept && (in_data.mode == MODE_REVERSE))
            rev_next = !rev_reg;
    end

    always_comb
    begin
        out_data_next              = '0;
        out_data_next.entry_count  = 5'(count_next);
        out_data_next.error_code   = ERR_OK;
        if (take_head)
        begin
            out_data_next.popped_value = cell_data[0];
            out_data_next.popped_valid = 1'b1;
        end
        else if (take_tail)
        begin
            out_data_next.popped_value = cell_data[tail_idx];
            out_data_next.popped_valid = 1'b1;
        end
        case (in_data.mode)
            MODE_PUSH_BACK: if (full)  out_data_next.error_code = ERR_FULL;
            MODE_POP_FRONT,
            MODE_POP_BACK:  if (empty) out_data_next.error_code = ERR_EMPTY;
            default:        out_data_next.error_code = ERR_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> (count_reg == $past(count_reg)) && (rev_reg == $past(rev_reg)))
        else $error("state changed without a request beat");

    a_pop_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.popped_valid |-> out_data_reg.error_code == ERR_OK)
        else $error("popped word flagged with error");

endmodule

@@ tb/deque_checker.sv @@
`timescale 1ns / 1ps
// Checker for the deque with reverse: watches both channels, predicts each result
// beat from its own ring model and compares field by field. Depends on dwr_pkg.
module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  dwr_pkg::req_t in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  dwr_pkg::rsp_t out_data,
    output int            mismatch_count,
    output int            pending_count
);
    import dwr_pkg::*;

    logic signed [31:0] ring_words [DEPTH];
    int                 front_pos;
    int                 word_count;
    logic               walk_down;
    rsp_t               pending_answers [$];

    function automatic int ring_slot(int pos);
        if (walk_down)
            return (front_pos + DEPTH - pos) % DEPTH;
        return (front_pos + pos) % DEPTH;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t a;
        a = '0;
        a.error_code = ERR_OK;
        case (r.mode)
            MODE_PUSH_BACK:
            begin
                if (word_count >= DEPTH)
                    a.error_code = ERR_FULL;
                else
                begin
                    ring_words[ring_slot(word_count)] = r.push_value;
                    word_count++;
                end
            end
            MODE_POP_FRONT:
            begin
                if (word_count == 0)
                    a.error_code = ERR_EMPTY;
                else
                begin
                    a.popped_value = ring_words[ring_slot(0)];
                    a.popped_valid = 1'b1;
                    front_pos = ring_slot(1);
                    word_count--;
                end
            end
            MODE_POP_BACK:
            begin
                if (word_count == 0)
                    a.error_code = ERR_EMPTY;
                else
                begin
                    a.popped_value = ring_words[ring_slot(word_count - 1)];
                    a.popped_valid = 1'b1;
                    word_count--;
                end
            end
            default:
            begin
                if (word_count != 0)
                    front_pos = ring_slot(word_count - 1);
                walk_down = !walk_down;
            end
        endcase
        a.entry_count = 5'(word_count);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            front_pos      = 0;
            word_count     = 0;
            walk_down      = 1'b0;
            mismatch_count = 0;
            pending_answers.delete();
            pending_count  = 0;
        end
        else
        begin
            // result beat is registered, so it always belongs to an older request
            if (out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected beat %0d %0b %0d %0d",
                                 $realtime, out_data.popped_value, out_data.popped_valid,
                                 out_data.error_code, out_data.entry_count);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (out_data.popped_value !== want.popped_value ||
                        out_data.popped_valid !== want.popped_valid ||
                        out_data.error_code   !== want.error_code   ||
                        out_data.entry_count  !== want.entry_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: exp %0d %0b %0d %0d, act %0d %0b %0d %0d",
                                     $realtime, want.popped_value, want.popped_valid,
                                     want.error_code, want.entry_count,
                                     out_data.popped_value, out_data.popped_valid,
                                     out_data.error_code, out_data.entry_count);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_answers.push_back(apply_request(in_data));
            pending_count = pending_answers.size();
        end
    end

endmodule

@@ tb/deque_with_reverse_top_tb.sv @@
`timescale 1ns / 1ps
// Top of the deque with reverse testbench: clock, reset, request stimulus and
// result stall. Depends on dwr_pkg, deque_with_reverse_top and deque_checker.
module deque_with_reverse_top_tb;
    import dwr_pkg::*;

    localparam int DEPTH = 16;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    req_t in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsp_t out_data;

    int   tx_idle_pct = 13;
    int   rx_idle_pct = 63;
    int   mismatch_count;
    int   pending_count;

    deque_with_reverse_top #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    deque_checker #(.DEPTH(DEPTH)) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);

    // called and returns at a falling edge
    task automatic send_request(input mode_t m, input logic signed [31:0] v);
        req_t r;
        r.mode       = m;
        r.push_value = v;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int n);
        int    left;
        int    seg;
        int    push_pct;
        int    pick;
        mode_t m;
        left = n;
        while (left > 0)
        begin
            seg = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 45;
                default: push_pct = 20;
            endcase
            for (int i = 0; i < seg && left > 0; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct)
                    m = MODE_PUSH_BACK;
                else if (pick < 92)
                    m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
                else
                    m = MODE_REVERSE;
                send_request(m, $urandom());
                left--;
            end
        end
    endtask

    initial
    begin
        logic signed [31:0] v;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue, single word, popping the last word
        send_request(MODE_POP_FRONT, $urandom());
        send_request(MODE_POP_BACK, $urandom());
        send_request(MODE_REVERSE, $urandom());
        send_request(MODE_PUSH_BACK, 32'sh1234_5678);
        send_request(MODE_REVERSE, $urandom());
        send_request(MODE_POP_BACK, $urandom());
        // fill with extreme words, overflow, reverse when full, pop from both ends
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = 32'sh0000_0000;
                3:       v = 32'shFFFF_FFFF;
                default: v = $urandom();
            endcase
            send_request(MODE_PUSH_BACK, v);
        end
        send_request(MODE_PUSH_BACK, $urandom());
        send_request(MODE_REVERSE, $urandom());
        send_request(MODE_POP_FRONT, $urandom());
        send_request(MODE_POP_BACK, $urandom());
        wait_drained();

        run_random(600);
        wait_drained();

        tx_idle_pct = 63;
        rx_idle_pct = 13;
        run_random(600);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(600);
        wait_drained();

        repeat (5) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
